>>> hw/rtl/assert_macros.svh
// Assertion helper macros shared by the crop box filter RTL.
// Each macro checks on the rising clock edge and is disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: whenever ante holds, cons holds in the same cycle.
`define CBF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: whenever ante holds, cons holds in the following cycle.
`define CBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cbf_pkg.sv
// Shared types and constants of the crop box point filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbf_pkg;

    localparam int COORD_W     = 16;   // coordinate width, in and out
    localparam int COEF_W      = 16;   // Q1.14 coefficient width
    localparam int FRAC_W      = 14;   // fraction bits of a coefficient
    localparam int PROD_W      = COORD_W + COEF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int EXTRA_W     = 32;
    localparam int CNT_OUT_W   = 16;   // width of the reported totals
    localparam int BOX_W       = 3 * COORD_W;
    localparam int ROW_W       = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int IN_DATA_W   = 3 * COORD_W + EXTRA_W;
    localparam int OUT_DATA_W  = 3 * COORD_W + EXTRA_W + 2 * CNT_OUT_W;

    // Identity rotation (1.0 in Q1.14 on the diagonal), zero translation.
    localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_4000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_4000_0000_0000;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));

    typedef enum logic [2:0] {
        REG_BOX_MIN      = 3'd0,
        REG_BOX_MAX      = 3'd1,
        REG_XFORM_ROW_X  = 3'd2,
        REG_XFORM_ROW_Y  = 3'd3,
        REG_XFORM_ROW_Z  = 3'd4,
        REG_KEEP_OUTSIDE = 3'd5
    } cbf_reg_e;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [BOX_W-1:0] box_min;
        logic [BOX_W-1:0] box_max;
        logic [ROW_W-1:0] row_x;
        logic [ROW_W-1:0] row_y;
        logic [ROW_W-1:0] row_z;
        logic             keep_outside;
    } cbf_cfg_t;

    // Fields that ride along with a point through the pipeline.
    typedef struct packed {
        logic               finite;
        logic               last;
        logic [EXTRA_W-1:0] extra;
    } cbf_side_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } cbf_point_t;

endpackage

`default_nettype wire

>>> hw/rtl/cbf_cfg.sv
// APB register file of the crop box filter: box limits, transform rows, mode.
// Depends on cbf_pkg.
`default_nettype none

module cbf_cfg
    import cbf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cbf_cfg_t                   cfg
);

    cbf_cfg_t cfg_reg;
    cbf_reg_e reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = cbf_reg_e'(paddr[APB_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_min      <= '0;
            cfg_reg.box_max      <= '0;
            cfg_reg.row_x        <= ROW_X_RESET;
            cfg_reg.row_y        <= ROW_Y_RESET;
            cfg_reg.row_z        <= ROW_Z_RESET;
            cfg_reg.keep_outside <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_BOX_MIN:      cfg_reg.box_min      <= pwdata[BOX_W-1:0];
                REG_BOX_MAX:      cfg_reg.box_max      <= pwdata[BOX_W-1:0];
                REG_XFORM_ROW_X:  cfg_reg.row_x        <= pwdata;
                REG_XFORM_ROW_Y:  cfg_reg.row_y        <= pwdata;
                REG_XFORM_ROW_Z:  cfg_reg.row_z        <= pwdata;
                REG_KEEP_OUTSIDE: cfg_reg.keep_outside <= pwdata[0];
                default: ;  // unmapped slots drop the write
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BOX_MIN:      prdata = APB_DATA_W'(cfg_reg.box_min);
            REG_BOX_MAX:      prdata = APB_DATA_W'(cfg_reg.box_max);
            REG_XFORM_ROW_X:  prdata = cfg_reg.row_x;
            REG_XFORM_ROW_Y:  prdata = cfg_reg.row_y;
            REG_XFORM_ROW_Z:  prdata = cfg_reg.row_z;
            REG_KEEP_OUTSIDE: prdata = APB_DATA_W'(cfg_reg.keep_outside);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/cbf_xform.sv
// Two-stage affine transform: nine Q1.14 products, then row sums with
// rounding, translation and saturation. Depends on cbf_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cbf_xform
    import cbf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cbf_cfg_t   cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire cbf_point_t in_point,
    input  wire cbf_side_t  in_side,
    output logic            out_valid,
    input  wire logic       out_ready,
    output cbf_point_t      out_point,
    output cbf_side_t       out_side
);

    logic [ROW_W-1:0]         rows [3];
    coord_t                   coords [3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    coord_t                   res_next [3];
    coord_t                   res_reg  [3];
    cbf_side_t                prod_side_reg;
    cbf_side_t                res_side_reg;
    logic                     prod_valid_reg;
    logic                     res_valid_reg;
    logic                     prod_en;
    logic                     res_en;

    assign rows[0]   = cfg.row_x;
    assign rows[1]   = cfg.row_y;
    assign rows[2]   = cfg.row_z;
    assign coords[0] = in_point.x;
    assign coords[1] = in_point.y;
    assign coords[2] = in_point.z;

    // A stage loads when it is empty or its contents move on.
    assign res_en   = !res_valid_reg || out_ready;
    assign prod_en  = !prod_valid_reg || res_en;
    assign in_ready = prod_en;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = $signed(rows[r][COEF_W*c +: COEF_W]) * coords[c];
            end
        end
    end

    // Round half up: add 2^13, arithmetic shift by 14 floors.
    always_comb begin
        logic signed [SUM_W-1:0]         acc;
        logic signed [SUM_W-FRAC_W-1:0]  rnd;
        logic signed [SUM_W-FRAC_W:0]    tot;
        logic signed [COORD_W-1:0]       trans;
        for (int r = 0; r < 3; r++) begin
            acc   = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                  + SUM_W'(prod_reg[r][2]) + ROUND_HALF;
            rnd   = acc[SUM_W-1:FRAC_W];
            trans = $signed(rows[r][3*COEF_W +: COORD_W]);
            tot   = (SUM_W-FRAC_W+1)'(rnd) + (SUM_W-FRAC_W+1)'(trans);
            if (tot > (SUM_W-FRAC_W+1)'(coord_t'({1'b0, {(COORD_W-1){1'b1}}}))) begin
                res_next[r] = {1'b0, {(COORD_W-1){1'b1}}};
            end else if (tot < (SUM_W-FRAC_W+1)'(coord_t'({1'b1, {(COORD_W-1){1'b0}}}))) begin
                res_next[r] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                res_next[r] = tot[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (prod_en) begin
                prod_valid_reg <= in_valid;
            end
            if (res_en) begin
                res_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_reg      <= prod_next;
            prod_side_reg <= in_side;
        end
        if (res_en) begin
            res_reg      <= res_next;
            res_side_reg <= prod_side_reg;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_point.x = res_reg[0];
    assign out_point.y = res_reg[1];
    assign out_point.z = res_reg[2];
    assign out_side    = res_side_reg;

    // A product stage that cannot advance must keep its point.
    `CBF_ASSERT_NEXT(a_prod_hold, aclk, aresetn, prod_valid_reg && !res_en,
        prod_valid_reg && $stable(prod_side_reg), "product stage lost a stalled item")

endmodule

`default_nettype wire

>>> hw/rtl/cbf_result.sv
// Box test, per-cloud counters and the output register of the filter.
// Depends on cbf_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cbf_result
    import cbf_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cbf_cfg_t              cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire cbf_point_t            in_point,
    input  wire cbf_side_t             in_side,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    logic [COUNT_BITS-1:0] inv_cnt_reg,  inv_cnt_next;
    logic [COUNT_BITS-1:0] kept_cnt_reg, kept_cnt_next;
    logic [COUNT_BITS-1:0] inv_total, kept_total;
    logic                  out_valid_reg;
    cbf_point_t            pt_reg, pt_next;
    logic [EXTRA_W-1:0]    extra_reg;
    logic [CNT_OUT_W-1:0]  inv_out_reg, kept_out_reg;
    logic                  kept_reg, last_reg;
    logic                  load;
    logic                  in_box;
    logic                  kept;

    assign in_ready = !out_valid_reg || m_tready;
    assign load     = in_valid && in_ready;

    always_comb begin
        in_box = (in_point.z > coord_t'(cfg.box_min[2*COORD_W +: COORD_W]))
              && (in_point.z < coord_t'(cfg.box_max[2*COORD_W +: COORD_W]))
              && (in_point.y > coord_t'(cfg.box_min[COORD_W +: COORD_W]))
              && (in_point.y < coord_t'(cfg.box_max[COORD_W +: COORD_W]))
              && (in_point.x > coord_t'(cfg.box_min[0 +: COORD_W]))
              && (in_point.x < coord_t'(cfg.box_max[0 +: COORD_W]));
        kept   = in_side.finite && (cfg.keep_outside ? !in_box : in_box);
        pt_next = in_side.finite ? in_point : '0;

        inv_total  = inv_cnt_reg;
        kept_total = kept_cnt_reg;
        if (!in_side.finite && inv_cnt_reg != '1) begin
            inv_total = inv_cnt_reg + 1'b1;
        end
        if (kept && kept_cnt_reg != '1) begin
            kept_total = kept_cnt_reg + 1'b1;
        end
        // Totals of the last point include it; counters restart after it.
        inv_cnt_next  = in_side.last ? '0 : inv_total;
        kept_cnt_next = in_side.last ? '0 : kept_total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            inv_cnt_reg   <= '0;
            kept_cnt_reg  <= '0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (load) begin
                inv_cnt_reg  <= inv_cnt_next;
                kept_cnt_reg <= kept_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pt_reg       <= pt_next;
            extra_reg    <= in_side.extra;
            inv_out_reg  <= CNT_OUT_W'(inv_total);
            kept_out_reg <= CNT_OUT_W'(kept_total);
            kept_reg     <= kept;
            last_reg     <= in_side.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kept_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {kept_out_reg, inv_out_reg, extra_reg, pt_reg.z, pt_reg.y, pt_reg.x};

    `CBF_ASSERT_NEXT(a_cloud_clear, aclk, aresetn, load && in_side.last,
        inv_cnt_reg == '0 && kept_cnt_reg == '0, "counters not cleared after cloud end")

    `CBF_ASSERT_NEXT(a_cnt_idle, aclk, aresetn, !load,
        $stable(inv_cnt_reg) && $stable(kept_cnt_reg), "counter moved without an item")

    `CBF_ASSERT_SAME(a_invalid_dropped, aclk, aresetn, load && !in_side.finite,
        !kept && pt_next == '0, "invalid point kept or given coordinates")

endmodule

`default_nettype wire

>>> hw/rtl/crop_box_point_filter.sv
// Crop box point filter: input register, two transform stages, result register.
// A point passes the input, product, row-sum and result registers on its way to m_*.
// Throughput: one point per cycle while m_tready is high; each stage advances
// when empty or its successor takes its item, so bubbles close up under backpressure.
// Reset: synchronous active-low aresetn empties the pipeline, clears the
// per-cloud counters and restores identity transform, zero box, keep-inside.
`default_nettype none

module crop_box_point_filter
    import cbf_pkg::*;
#(
    parameter int COUNT_BITS = 16  // width of the saturating per-cloud counters
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Point input channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y, point_z, point_extra
    input  wire logic                  s_tuser,   // point_finite
    input  wire logic                  s_tlast,   // last_in_cloud

    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // out_x, out_y, out_z, out_extra,
                                                  // invalid_total, kept_total
    output logic                       m_tuser,   // kept
    output logic                       m_tlast,   // cloud_done

    // Configuration port, one 64-bit register every 8 bytes.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cbf_cfg_t   cfg;

    // Input register stage.
    logic       in_valid_reg;
    cbf_point_t in_point_reg;
    cbf_side_t  in_side_reg;
    logic       in_en;

    // Transform to result stage.
    logic       xf_ready;
    logic       xf_valid;
    cbf_point_t xf_point;
    cbf_side_t  xf_side;
    logic       res_ready;

    cbf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The input register takes a new item when empty or when its item moves on.
    assign in_en    = !in_valid_reg || xf_ready;
    assign s_tready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en) begin
            in_point_reg.x     <= s_tdata[0 +: COORD_W];
            in_point_reg.y     <= s_tdata[COORD_W +: COORD_W];
            in_point_reg.z     <= s_tdata[2*COORD_W +: COORD_W];
            in_side_reg.extra  <= s_tdata[3*COORD_W +: EXTRA_W];
            in_side_reg.finite <= s_tuser;
            in_side_reg.last   <= s_tlast;
        end
    end

    // Products in the first stage, rounded and saturated rows in the second.
    cbf_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_ready  (xf_ready),
        .in_point  (in_point_reg),
        .in_side   (in_side_reg),
        .out_valid (xf_valid),
        .out_ready (res_ready),
        .out_point (xf_point),
        .out_side  (xf_side)
    );

    // Box test and counters feed the output register directly.
    cbf_result #(
        .COUNT_BITS (COUNT_BITS)
    ) u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (xf_valid),
        .in_ready (res_ready),
        .in_point (xf_point),
        .in_side  (xf_side),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for crop_box_point_filter: drives points on the s_ stream,
// programs the box and transform over APB and checks every m_ result field.
// Depends on cbf_pkg (widths, reset rows, register codes) and the RTL top only.
`default_nettype none

module tb_top;
    import cbf_pkg::*;

    // Run control
    localparam int  IDLE_PCT    = 19;         // chance per cycle that a side idles
    localparam int  PIPE_SLACK  = 8;          // settle wait, a bit over the pipeline depth
    localparam int  CYCLE_LIMIT = 1_000_000;  // slowest legal run is well under this
    localparam int  REG_COUNT   = 6;          // first unmapped register index
    localparam int  LONG_RUN    = 40;         // points of each kind in the long cloud
    localparam int  RAND_PHASES = 8;
    localparam int  PHASE_ITEMS = 200;
    localparam int  MAX_REPORTS = 10;

    localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;   // 1.0 in Q1.14

    typedef struct packed {
        coord_t             x;
        coord_t             y;
        coord_t             z;
        logic               finite;
        logic [EXTRA_W-1:0] extra;
        logic               last;
    } lidar_point_t;

    typedef struct packed {
        logic                 kept;
        coord_t               x;
        coord_t               y;
        coord_t               z;
        logic [EXTRA_W-1:0]   extra;
        logic [CNT_OUT_W-1:0] invalid_total;
        logic [CNT_OUT_W-1:0] kept_total;
        logic                 done;
    } filt_result_t;

    // DUT ports
    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // point_x, point_y, point_z, point_extra
    logic                  s_tuser;   // point_finite
    logic                  s_tlast;   // last_in_cloud
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // out_x, out_y, out_z, out_extra,
                                      // invalid_total, kept_total
    logic                  m_tuser;   // kept
    logic                  m_tlast;   // cloud_done
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    crop_box_point_filter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the block: register copy plus the two per-cloud counters
    cbf_cfg_t             cfg_shadow;
    logic [CNT_OUT_W-1:0] invalid_seen;
    logic [CNT_OUT_W-1:0] kept_seen;
    filt_result_t         pending_results[$];

    // Bookkeeping
    int  cycle_count;
    int  fail_count;
    int  points_sent;
    int  results_checked;
    int  kept_results;
    int  clouds_closed;
    int  cfg_writes;
    bit  send_idle_en;
    bit  recv_stall_en;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic logic [CNT_OUT_W-1:0] sat_inc(input logic [CNT_OUT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // One transform row: exact sum, round half up at bit 14, add offset, clamp.
    function automatic coord_t row_apply(input logic [ROW_W-1:0] row,
                                         input coord_t x, input coord_t y,
                                         input coord_t z);
        longint sum;
        sum = longint'($signed(row[15:0]))  * longint'(x)
            + longint'($signed(row[31:16])) * longint'(y)
            + longint'($signed(row[47:32])) * longint'(z);
        sum = ((sum + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W)
            + longint'($signed(row[63:48]));
        if (sum > COORD_HI)
            return coord_t'(COORD_HI);
        if (sum < COORD_LO)
            return coord_t'(COORD_LO);
        return coord_t'(sum);
    endfunction

    function automatic filt_result_t filter_point(input lidar_point_t p);
        filt_result_t r;
        logic         in_box;
        r       = '0;
        r.extra = p.extra;
        r.done  = p.last;
        if (!p.finite) begin
            // dropped: coords forced to zero, only the invalid count moves
            invalid_seen = sat_inc(invalid_seen);
        end else begin
            r.x = row_apply(cfg_shadow.row_x, p.x, p.y, p.z);
            r.y = row_apply(cfg_shadow.row_y, p.x, p.y, p.z);
            r.z = row_apply(cfg_shadow.row_z, p.x, p.y, p.z);
            // strict on both sides, so an empty or inverted box holds nothing
            in_box = (r.x > $signed(cfg_shadow.box_min[15:0]))
                  && (r.x < $signed(cfg_shadow.box_max[15:0]))
                  && (r.y > $signed(cfg_shadow.box_min[31:16]))
                  && (r.y < $signed(cfg_shadow.box_max[31:16]))
                  && (r.z > $signed(cfg_shadow.box_min[47:32]))
                  && (r.z < $signed(cfg_shadow.box_max[47:32]));
            r.kept = cfg_shadow.keep_outside ? !in_box : in_box;
            if (r.kept)
                kept_seen = sat_inc(kept_seen);
        end
        r.invalid_total = invalid_seen;
        r.kept_total    = kept_seen;
        // totals of the last point include it; clear for the next cloud
        if (p.last) begin
            invalid_seen = '0;
            kept_seen    = '0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input monitor and result checker, both sampled at the clock edge
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        lidar_point_t p;
        filt_result_t got;
        filt_result_t want;
        if (aresetn && s_tvalid && s_tready) begin
            p.x      = s_tdata[15:0];
            p.y      = s_tdata[31:16];
            p.z      = s_tdata[47:32];
            p.extra  = s_tdata[79:48];
            p.finite = s_tuser;
            p.last   = s_tlast;
            pending_results = {pending_results, filter_point(p)};
            points_sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.x             = m_tdata[15:0];
            got.y             = m_tdata[31:16];
            got.z             = m_tdata[47:32];
            got.extra         = m_tdata[79:48];
            got.invalid_total = m_tdata[95:80];
            got.kept_total    = m_tdata[111:96];
            got.kept          = m_tuser;
            got.done          = m_tlast;
            results_checked++;
            if (got.kept === 1'b1)
                kept_results++;
            if (got.done === 1'b1)
                clouds_closed++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0d] result with nothing outstanding", cycle_count);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("[%0d] mismatch on result %0d", cycle_count,
                                 results_checked);
                        $display("  exp kept=%b x=%0d y=%0d z=%0d extra=%h inv=%0d n=%0d last=%b",
                                 want.kept, want.x, want.y, want.z, want.extra,
                                 want.invalid_total, want.kept_total, want.done);
                        $display("  got kept=%b x=%0d y=%0d z=%0d extra=%h inv=%0d n=%0d last=%b",
                                 got.kept, got.x, got.y, got.z, got.extra,
                                 got.invalid_total, got.kept_total, got.done);
                    end
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk)
        m_tready <= !recv_stall_en || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Holds tvalid high from one item straight into the next; it only drops
    // on a random gap or in stop_points, never twice in one step.
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input logic finite, input logic [EXTRA_W-1:0] extra,
                              input logic last);
        while (send_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {extra, z, y, x};
        s_tuser  <= finite;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic stop_points();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Sender pauses until every outstanding result is back, then lets the
    // pipeline settle. Registers are only touched after this.
    task automatic wait_results();
        stop_points();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    task automatic reg_write(input int idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        cfg_writes++;
        case (idx)
            REG_BOX_MIN:      cfg_shadow.box_min      = value[BOX_W-1:0];
            REG_BOX_MAX:      cfg_shadow.box_max      = value[BOX_W-1:0];
            REG_XFORM_ROW_X:  cfg_shadow.row_x        = value;
            REG_XFORM_ROW_Y:  cfg_shadow.row_y        = value;
            REG_XFORM_ROW_Z:  cfg_shadow.row_z        = value;
            REG_KEEP_OUTSIDE: cfg_shadow.keep_outside = value[0];
            default: ;  // unmapped: block ignores it
        endcase
    endtask

    // Biased coordinate: full range, near the typical box, or a corner value.
    function automatic coord_t pick_coord();
        case ($urandom_range(3))
            0:       return coord_t'($urandom);
            1:       return coord_t'(int'($urandom_range(1200)) - 600);
            2: begin
                case ($urandom_range(3))
                    0:       return coord_t'(COORD_LO);
                    1:       return coord_t'(COORD_HI);
                    2:       return coord_t'(-1);
                    default: return coord_t'(0);
                endcase
            end
            default: return coord_t'(int'($urandom_range(160)) - 80);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset config: identity rows, zero box, keep inside -> nothing kept.
    task automatic test_power_on_state();
        send_point(coord_t'(COORD_LO), coord_t'(COORD_HI), coord_t'(0), 1'b1, '1, 1'b0);
        send_point(coord_t'(COORD_HI), coord_t'(COORD_LO), coord_t'(-1), 1'b1, '0, 1'b0);
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 32'hA5A5_A5A5, 1'b0);
        send_point(coord_t'(1), coord_t'(-1), coord_t'(0), 1'b0, 32'h5A5A_5A5A, 1'b1);
    endtask

    // +-100 box: inside, on a max and a min face, outside; then inverted mode and box.
    task automatic test_box_boundaries();
        wait_results();
        reg_write(REG_BOX_MIN, {16'h0, coord_t'(-100), coord_t'(-100), coord_t'(-100)});
        reg_write(REG_BOX_MAX, {16'h0, coord_t'(100), coord_t'(100), coord_t'(100)});
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 32'h0000_0001, 1'b0);
        send_point(coord_t'(99), coord_t'(-99), coord_t'(99), 1'b1, 32'h0000_0002, 1'b0);
        // on max face
        send_point(coord_t'(100), coord_t'(0), coord_t'(0), 1'b1, 32'h0000_0003, 1'b0);
        // on min face
        send_point(coord_t'(0), coord_t'(-100), coord_t'(0), 1'b1, 32'h0000_0004, 1'b0);
        send_point(coord_t'(0), coord_t'(0), coord_t'(101), 1'b1, 32'h0000_0005, 1'b0);
        // invalid ends cloud
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 32'h0000_0006, 1'b1);
        wait_results();
        reg_write(REG_KEEP_OUTSIDE, 64'd1);
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 32'h0000_0007, 1'b0);
        send_point(coord_t'(100), coord_t'(0), coord_t'(0), 1'b1, 32'h0000_0008, 1'b0);
        send_point(coord_t'(COORD_LO), coord_t'(COORD_LO), coord_t'(COORD_LO), 1'b1,
                   32'h0000_0009, 1'b1);
        // inverted box holds nothing, in either mode
        wait_results();
        reg_write(REG_BOX_MIN, {16'h0, coord_t'(100), coord_t'(100), coord_t'(100)});
        reg_write(REG_BOX_MAX, {16'h0, coord_t'(-100), coord_t'(-100), coord_t'(-100)});
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 32'h0000_000A, 1'b0);
        wait_results();
        reg_write(REG_KEEP_OUTSIDE, 64'd0);
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 32'h0000_000B, 1'b1);
    endtask

    // Coefficient and offset extremes, saturation both ways, rounding ties.
    task automatic test_transform_extremes();
        wait_results();
        reg_write(REG_BOX_MIN, {16'h0, {3{coord_t'(COORD_LO)}}});
        reg_write(REG_BOX_MAX, {16'h0, {3{coord_t'(COORD_HI)}}});
        reg_write(REG_XFORM_ROW_X, {4{16'h7FFF}});
        reg_write(REG_XFORM_ROW_Y, {4{16'h8000}});
        reg_write(REG_XFORM_ROW_Z, 64'h0000_0000_0000_0001);  // x / 2^14
        send_point(coord_t'(COORD_HI), coord_t'(COORD_HI), coord_t'(COORD_HI), 1'b1,
                   32'hFFFF_0000, 1'b0);
        send_point(coord_t'(COORD_LO), coord_t'(COORD_LO), coord_t'(COORD_LO), 1'b1,
                   32'h0000_FFFF, 1'b0);
        // +0.5 rounds up
        send_point(coord_t'(8192), coord_t'(0), coord_t'(0), 1'b1, 32'h1111_1111, 1'b0);
        // -0.5 rounds to 0
        send_point(coord_t'(-8192), coord_t'(0), coord_t'(0), 1'b1, 32'h2222_2222, 1'b0);
        send_point(coord_t'(-8193), coord_t'(0), coord_t'(0), 1'b1, 32'h3333_3333, 1'b0);
        send_point(coord_t'(8191), coord_t'(0), coord_t'(0), 1'b1, 32'h4444_4444, 1'b1);
    endtask

    // Writes past the last register must leave the config alone.
    task automatic test_unmapped_registers();
        wait_results();
        reg_write(REG_COUNT, '1);
        reg_write(REG_COUNT + 1, '1);
        send_point(coord_t'(8192), coord_t'(-5), coord_t'(7), 1'b1, 32'hDEAD_BEEF, 1'b1);
    endtask

    // One phase: random config, then random points with random cloud lengths.
    task automatic test_random_phase(input int n_items, input bit quiet);
        logic [BOX_W-1:0] bmin;
        logic [BOX_W-1:0] bmax;
        logic [ROW_W-1:0] row;
        int               ctr;
        int               half;
        int               rot_mode;
        int               cloud_mean;
        wait_results();
        send_idle_en  = !quiet;
        recv_stall_en = !quiet;
        for (int a = 0; a < 3; a++) begin
            ctr  = int'($urandom_range(800)) - 400;
            half = $urandom_range(350);
            bmin[16*a +: 16] = coord_t'(ctr - half);
            bmax[16*a +: 16] = coord_t'(ctr + half);
        end
        if ($urandom_range(5) == 0)
            bmin = BOX_W'({$urandom, $urandom});
        if ($urandom_range(5) == 0)
            bmax = BOX_W'({$urandom, $urandom});
        reg_write(REG_BOX_MIN, {$urandom, $urandom});   // upper bits dropped
        reg_write(REG_BOX_MIN, {16'h0, bmin});
        reg_write(REG_BOX_MAX, {16'h0, bmax});
        rot_mode = $urandom_range(3);
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                case (rot_mode)
                    0:       row[16*k +: 16] = (k == r) ? COEF_ONE : '0;
                    1:       row[16*k +: 16] = 16'(int'($urandom_range(32768)) - 16384);
                    2:       row[16*k +: 16] = 16'($urandom);
                    default: row[16*k +: 16] = (k == 2 - r) ? COEF_ONE : '0;
                endcase
            end
            row[63:48] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                 : 16'(int'($urandom_range(600)) - 300);
            reg_write(REG_XFORM_ROW_X + r, row);
        end
        reg_write(REG_KEEP_OUTSIDE, {$urandom, $urandom});  // only bit 0 counts
        case ($urandom_range(2))
            0:       cloud_mean = 3;
            1:       cloud_mean = 20;
            default: cloud_mean = 80;
        endcase
        for (int i = 0; i < n_items; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(),
                       $urandom_range(99) < 85, $urandom,
                       $urandom_range(cloud_mean) == 0);
        send_idle_en  = 1'b1;
        recv_stall_en = 1'b1;
    endtask

    // One long cloud with a run of invalid and then a run of valid points,
    // then a short cloud to see the counters cleared. Empty box with
    // keep-outside keeps every valid point. Runs with no idling on either side.
    task automatic test_long_cloud();
        wait_results();
        send_idle_en  = 1'b0;
        recv_stall_en = 1'b0;
        reg_write(REG_BOX_MIN, '0);
        reg_write(REG_BOX_MAX, '0);
        reg_write(REG_XFORM_ROW_X, ROW_X_RESET);
        reg_write(REG_XFORM_ROW_Y, ROW_Y_RESET);
        reg_write(REG_XFORM_ROW_Z, ROW_Z_RESET);
        reg_write(REG_KEEP_OUTSIDE, 64'd1);
        for (int i = 0; i < LONG_RUN; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, $urandom, 1'b0);
        for (int i = 0; i < LONG_RUN; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(), 1'b1, $urandom,
                       i == LONG_RUN - 1);
        for (int i = 0; i < 3; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(), i != 1, $urandom, i == 2);
        send_idle_en  = 1'b1;
        recv_stall_en = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        cfg_shadow.box_min      = '0;
        cfg_shadow.box_max      = '0;
        cfg_shadow.row_x        = ROW_X_RESET;
        cfg_shadow.row_y        = ROW_Y_RESET;
        cfg_shadow.row_z        = ROW_Z_RESET;
        cfg_shadow.keep_outside = 1'b0;
        invalid_seen    = '0;
        kept_seen       = '0;
        cycle_count     = 0;
        fail_count      = 0;
        points_sent     = 0;
        results_checked = 0;
        kept_results    = 0;
        clouds_closed   = 0;
        cfg_writes      = 0;
        send_idle_en    = 1'b1;
        recv_stall_en   = 1'b1;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_on_state();
        test_box_boundaries();
        test_transform_extremes();
        test_unmapped_registers();
        for (int ph = 0; ph < RAND_PHASES; ph++)
            test_random_phase(PHASE_ITEMS, ph == 3);   // phase 3 runs with no idling
        test_long_cloud();
        wait_results();

        $display("%0d points in, %0d results checked (%0d kept), %0d clouds closed",
                 points_sent, results_checked, kept_results, clouds_closed);
        $display("%0d register writes across %0d random configs plus edge setups",
                 cfg_writes, RAND_PHASES);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failing results", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/cbf_pkg.sv
hw/rtl/cbf_cfg.sv
hw/rtl/cbf_xform.sv
hw/rtl/cbf_result.sv
hw/rtl/crop_box_point_filter.sv
verif/tb_top.sv
